@@ hw/rtl/mbj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbj_pkg
// Shared types and constants of the mesh barycentric Jacobian unit: item
// kinds, table defaults and the arithmetic widths of the corner datapath.
// ----------------------------------------------------------------------------
package mbj_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_PIXEL    = 2'd2;

    // Table defaults and raster size
    localparam int DEF_MAX_VERTICES  = 1024;
    localparam int DEF_MAX_TRIANGLES = 2048;
    localparam int MAX_RESOLUTION    = 256;

    // Field widths
    localparam int POS_W = 16;
    localparam int VAR_W = 16;
    localparam int IDX_W = 10;
    localparam int PIX_W = 8;
    localparam int POS_FRAC = 6;     // pixel to Q.6
    localparam int VAR_FRAC = 12;    // Q4.12 variation

    // Datapath widths
    localparam int DIF_W  = 17;                  // edge and offset terms
    localparam int PRD_W  = 34;                  // 17 x 17 products
    localparam int DET_W  = 35;                  // d, a, b
    localparam int NUM_W  = 37;                  // d - a - b
    localparam int MAG_W  = 36;                  // |d - a - b|
    localparam int DEN_W  = 35;                  // |d|
    localparam int FRAC_W = 16;                  // weight fraction bits
    localparam int QB     = 48;                  // quotient bits kept
    localparam int HI_W   = MAG_W + FRAC_W - QB; // dividend bits above QB
    localparam int REM_W  = DEN_W;
    localparam int PROD_W = QB + VAR_W;          // |w| * |var|
    localparam int TERM_W = PROD_W - VAR_FRAC + 1;
    localparam int SUM_W  = TERM_W + 2;
    localparam int OUT_W  = 32;

    // Corner lane register stages: four front stages, QB + 1 divider stages,
    // multiply, sign
    localparam int LANE_LAT = 4 + QB + 1 + 2;

    // One vertex table entry
    typedef struct packed {
        logic signed [VAR_W-1:0] var_y;
        logic signed [VAR_W-1:0] var_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } vtx_t;

endpackage

@@ hw/rtl/mbj_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbj_ram
// Generic simple dual-port RAM: one write port, one registered read port,
// read-first when both ports hit the same address.
// ----------------------------------------------------------------------------
module mbj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mbj_corner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbj_corner
// One triangle corner: determinant and edge terms, restoring quotient of
// the barycentric weight one bit per stage, weight clamp and the weighted
// variation terms, all advancing together on run.
// ----------------------------------------------------------------------------
module mbj_corner import mbj_pkg::*; (
    input  logic                     clk,
    input  logic                     run,
    input  vtx_t                     v0,      // this corner
    input  vtx_t                     v1,      // next corner
    input  vtx_t                     v2,      // corner after that
    input  logic signed [DIF_W-1:0]  tx,
    input  logic signed [DIF_W-1:0]  ty,
    output logic signed [TERM_W-1:0] term_x,
    output logic signed [TERM_W-1:0] term_y
);

    // Front stages
    logic signed [DIF_W-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg, dx_reg, dy_reg;
    logic signed [PRD_W-1:0] pd1_reg, pd2_reg, pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic signed [DET_W-1:0] d3_reg, a3_reg, b3_reg, d4_reg;
    logic signed [NUM_W-1:0] num4_reg;
    logic signed [VAR_W-1:0] vx_pipe_reg [1:4];
    logic signed [VAR_W-1:0] vy_pipe_reg [1:4];

    // Divider stages
    logic [REM_W-1:0] rem_reg  [0:QB];
    logic [QB-1:0]    low_reg  [0:QB];
    logic [QB-1:0]    quo_reg  [0:QB];
    logic [DEN_W-1:0] den_reg  [0:QB];
    logic             dz_reg   [0:QB];
    logic             ov_reg   [0:QB];
    logic             negx_reg [0:QB];
    logic             negy_reg [0:QB];
    logic [VAR_W-1:0] vxm_reg  [0:QB];
    logic [VAR_W-1:0] vym_reg  [0:QB];

    // Back stages
    logic [PROD_W-1:0]        prodx_reg, prody_reg;
    logic                     dz6_reg, negx6_reg, negy6_reg;
    logic signed [TERM_W-1:0] termx_reg, termy_reg;

    // Stage-0 operands and the clamped weight
    logic [MAG_W-1:0] nmag;
    logic [DEN_W-1:0] dmag;
    logic             sgn;
    logic [QB-1:0]    wmag;

    // Edges and pixel offset from this corner
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            e1x_reg <= DIF_W'(v1.pos_x) - DIF_W'(v0.pos_x);
            e1y_reg <= DIF_W'(v1.pos_y) - DIF_W'(v0.pos_y);
            e2x_reg <= DIF_W'(v2.pos_x) - DIF_W'(v0.pos_x);
            e2y_reg <= DIF_W'(v2.pos_y) - DIF_W'(v0.pos_y);
            dx_reg  <= tx - DIF_W'(v0.pos_x);
            dy_reg  <= ty - DIF_W'(v0.pos_y);
            vx_pipe_reg[1] <= v0.var_x;
            vy_pipe_reg[1] <= v0.var_y;
            for (int i = 2; i <= 4; i++)
            begin
                vx_pipe_reg[i] <= vx_pipe_reg[i-1];
                vy_pipe_reg[i] <= vy_pipe_reg[i-1];
            end
        end
    end

    // Cross products, then d, a, b, then the weight numerator
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            pd1_reg <= PRD_W'(e1x_reg) * PRD_W'(e2y_reg);
            pd2_reg <= PRD_W'(e1y_reg) * PRD_W'(e2x_reg);
            pa1_reg <= PRD_W'(dx_reg) * PRD_W'(e2y_reg);
            pa2_reg <= PRD_W'(dy_reg) * PRD_W'(e2x_reg);
            pb1_reg <= PRD_W'(dy_reg) * PRD_W'(e1x_reg);
            pb2_reg <= PRD_W'(dx_reg) * PRD_W'(e1y_reg);
            d3_reg  <= DET_W'(pd1_reg) - DET_W'(pd2_reg);
            a3_reg  <= DET_W'(pa1_reg) - DET_W'(pa2_reg);
            b3_reg  <= DET_W'(pb1_reg) - DET_W'(pb2_reg);
            num4_reg <= NUM_W'(d3_reg) - NUM_W'(a3_reg) - NUM_W'(b3_reg);
            d4_reg   <= d3_reg;
        end
    end

    // Magnitudes and quotient sign
    always_comb
    begin
        nmag = num4_reg[NUM_W-1] ? MAG_W'(-num4_reg) : MAG_W'(num4_reg);
        dmag = d4_reg[DET_W-1] ? DEN_W'(-d4_reg) : DEN_W'(d4_reg);
        sgn  = num4_reg[NUM_W-1] ^ d4_reg[DET_W-1];
    end

    // Load the divider: top dividend bits seed the remainder
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            rem_reg[0]  <= REM_W'(nmag[MAG_W-1 -: HI_W]);
            low_reg[0]  <= {nmag[MAG_W-HI_W-1:0], {FRAC_W{1'b0}}};
            quo_reg[0]  <= '0;
            den_reg[0]  <= dmag;
            dz_reg[0]   <= (d4_reg == '0);
            ov_reg[0]   <= (DEN_W'(nmag[MAG_W-1 -: HI_W]) >= dmag);
            negx_reg[0] <= sgn ^ vx_pipe_reg[4][VAR_W-1];
            negy_reg[0] <= sgn ^ vy_pipe_reg[4][VAR_W-1];
            vxm_reg[0]  <= vx_pipe_reg[4][VAR_W-1] ? VAR_W'(-vx_pipe_reg[4])
                                                   : VAR_W'(vx_pipe_reg[4]);
            vym_reg[0]  <= vy_pipe_reg[4][VAR_W-1] ? VAR_W'(-vy_pipe_reg[4])
                                                   : VAR_W'(vy_pipe_reg[4]);
        end
    end

    // One quotient bit per stage
    for (genvar s = 1; s <= QB; s++)
    begin : g_div
        logic [REM_W:0] trial;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[s-1], low_reg[s-1][QB-1]};
            ge    = (trial >= {1'b0, den_reg[s-1]});
        end

        always_ff @(posedge clk)
        begin
            if (run)
            begin
                rem_reg[s]  <= ge ? REM_W'(trial - {1'b0, den_reg[s-1]})
                                  : REM_W'(trial);
                low_reg[s]  <= {low_reg[s-1][QB-2:0], 1'b0};
                quo_reg[s]  <= {quo_reg[s-1][QB-2:0], ge};
                den_reg[s]  <= den_reg[s-1];
                dz_reg[s]   <= dz_reg[s-1];
                ov_reg[s]   <= ov_reg[s-1];
                negx_reg[s] <= negx_reg[s-1];
                negy_reg[s] <= negy_reg[s-1];
                vxm_reg[s]  <= vxm_reg[s-1];
                vym_reg[s]  <= vym_reg[s-1];
            end
        end
    end

    // Clamp the weight magnitude at one half of the quotient range
    always_comb
    begin
        if (ov_reg[QB] || (quo_reg[QB][QB-1] && (|quo_reg[QB][QB-2:0])))
        begin
            wmag = {1'b1, {(QB-1){1'b0}}};
        end
        else
        begin
            wmag = quo_reg[QB];
        end
    end

    // Weight times variation, then truncate and apply the sign; zero when d is zero
    always_ff @(posedge clk)
    begin
        if (run)
        begin
            prodx_reg <= PROD_W'(wmag) * PROD_W'(vxm_reg[QB]);
            prody_reg <= PROD_W'(wmag) * PROD_W'(vym_reg[QB]);
            dz6_reg   <= dz_reg[QB];
            negx6_reg <= negx_reg[QB];
            negy6_reg <= negy_reg[QB];
            if (dz6_reg)
            begin
                termx_reg <= '0;
                termy_reg <= '0;
            end
            else
            begin
                termx_reg <= negx6_reg ? -TERM_W'(prodx_reg[PROD_W-1:VAR_FRAC])
                                       :  TERM_W'(prodx_reg[PROD_W-1:VAR_FRAC]);
                termy_reg <= negy6_reg ? -TERM_W'(prody_reg[PROD_W-1:VAR_FRAC])
                                       :  TERM_W'(prody_reg[PROD_W-1:VAR_FRAC]);
            end
        end
    end

    assign term_x = termx_reg;
    assign term_y = termy_reg;

endmodule

@@ hw/rtl/mesh_barycentric_jacobian_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_barycentric_jacobian_unit
// Per-pixel Jacobian of a piecewise affine warp: vertex and triangle tables
// loaded over the input stream, three pipelined corner lanes per pixel.
//
//   channel  dir  beat contents
//   s_*      in   vertex write, triangle write or pixel (kind on s_tuser)
//   m_*      out  jac_x, jac_y for each pixel beat
//
// One beat per cycle while the pipeline advances; a pixel result passes the
// table lookups, the 48-stage quotient divider of each lane and the sum.
// Table writes take effect at once and produce no output beat.
// Reset clears the valid bits only; the tables hold nothing until written.
// The pipeline advances unless its last stage holds a result while the
// output register is full and m_tready is low; bubbles still close up.
// ----------------------------------------------------------------------------
module mesh_barycentric_jacobian_unit import mbj_pkg::*; #(
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, vertex_pos_x, vertex_pos_y, vertex_var_x, vertex_var_y,
    // corner_a, corner_b, corner_c, pixel_x, pixel_y, label, zero pad
    input  logic [135:0] s_tdata,
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // jac_x, jac_y
);

    localparam int VA_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TA_W   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int PIPE_N = LANE_LAT + 3;

    // Input fields
    logic [10:0]      entry_index;
    vtx_t             vtx_in;
    logic [IDX_W-1:0] corner_a, corner_b, corner_c;
    logic [PIX_W-1:0] pixel_x, pixel_y;
    logic [11:0]      label;
    logic [1:0]       kind;

    assign entry_index   = s_tdata[10:0];
    assign vtx_in.pos_x  = s_tdata[26:11];
    assign vtx_in.pos_y  = s_tdata[42:27];
    assign vtx_in.var_x  = s_tdata[58:43];
    assign vtx_in.var_y  = s_tdata[74:59];
    assign corner_a      = s_tdata[84:75];
    assign corner_b      = s_tdata[94:85];
    assign corner_c      = s_tdata[104:95];
    assign pixel_x       = s_tdata[112:105];
    assign pixel_y       = s_tdata[120:113];
    assign label         = s_tdata[132:121];
    assign kind          = s_tuser;

    logic run, accept, out_load;
    logic out_valid_reg;
    logic vld_reg [1:PIPE_N];

    // Stall only when a finished result meets a full, blocked output
    assign out_load = !out_valid_reg || m_tready;
    assign run      = out_load || !vld_reg[PIPE_N];
    assign s_tready = run;
    assign accept   = s_tvalid && run;

    // Table writes
    logic [31:0] entry32, label_m1;
    logic        vtx_we, tri_we;

    assign entry32  = 32'(entry_index);
    assign label_m1 = 32'(label) - 32'd1;
    assign vtx_we   = accept && (kind == KIND_VERTEX) && (entry32 < 32'(MAX_VERTICES));
    assign tri_we   = accept && (kind == KIND_TRIANGLE) && (entry32 < 32'(MAX_TRIANGLES));

    // Triangle lookup, stage 1
    logic [3*IDX_W-1:0] tri_q;
    logic [PIX_W-1:0]   px1_reg, py1_reg, px2_reg, py2_reg;
    logic               ok1_reg, ok2_reg;

    mbj_ram #(.WIDTH(3*IDX_W), .DEPTH(MAX_TRIANGLES), .AW(TA_W)) u_tri_ram (
        .clk   (clk),
        .we    (tri_we),
        .waddr (entry32[TA_W-1:0]),
        .wdata ({corner_c, corner_b, corner_a}),
        .re    (run),
        .raddr (label_m1[TA_W-1:0]),
        .rdata (tri_q)
    );

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            px1_reg <= pixel_x;
            py1_reg <= pixel_y;
            ok1_reg <= (label != '0) && (label_m1 < 32'(MAX_TRIANGLES))
                    && (32'(pixel_x) < 32'(MAX_RESOLUTION))
                    && (32'(pixel_y) < 32'(MAX_RESOLUTION));
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            ok2_reg <= ok1_reg;
        end
    end

    // Vertex lookups, stage 2: one table copy per corner
    vtx_t vq   [3];
    vtx_t feed [3];
    logic oob2_reg [3];

    for (genvar j = 0; j < 3; j++)
    begin : g_vtx
        logic [31:0] idx32;

        assign idx32 = 32'(tri_q[j*IDX_W +: IDX_W]);

        mbj_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES), .AW(VA_W)) u_vtx_ram (
            .clk   (clk),
            .we    (vtx_we),
            .waddr (entry32[VA_W-1:0]),
            .wdata (vtx_in),
            .re    (run),
            .raddr (idx32[VA_W-1:0]),
            .rdata (vq[j])
        );

        always_ff @(posedge clk)
        begin
            if (run)
            begin
                oob2_reg[j] <= (idx32 >= 32'(MAX_VERTICES));
            end
        end

        // Zero vertices make every determinant zero for a dropped pixel
        assign feed[j] = (ok2_reg && !oob2_reg[j]) ? vq[j] : '0;
    end

    // Corner lanes
    logic signed [DIF_W-1:0]  tx, ty;
    logic signed [TERM_W-1:0] term_x [3];
    logic signed [TERM_W-1:0] term_y [3];

    assign tx = {{(DIF_W-PIX_W-POS_FRAC){1'b0}}, px2_reg, {POS_FRAC{1'b0}}};
    assign ty = {{(DIF_W-PIX_W-POS_FRAC){1'b0}}, py2_reg, {POS_FRAC{1'b0}}};

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        mbj_corner u_corner (
            .clk    (clk),
            .run    (run),
            .v0     (feed[j]),
            .v1     (feed[(j+1)%3]),
            .v2     (feed[(j+2)%3]),
            .tx     (tx),
            .ty     (ty),
            .term_x (term_x[j]),
            .term_y (term_y[j])
        );
    end

    // Sum the three corners
    logic signed [SUM_W-1:0] sumx_reg, sumy_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            sumx_reg <= SUM_W'(term_x[0]) + SUM_W'(term_x[1]) + SUM_W'(term_x[2]);
            sumy_reg <= SUM_W'(term_y[0]) + SUM_W'(term_y[1]) + SUM_W'(term_y[2]);
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= PIPE_N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (run)
        begin
            vld_reg[1] <= accept && (kind == KIND_PIXEL);
            for (int i = 2; i <= PIPE_N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Saturate into the output register
    logic [OUT_W-1:0] jacx_next, jacy_next, jacx_reg, jacy_reg;

    always_comb
    begin
        if ((&sumx_reg[SUM_W-1:OUT_W-1]) || !(|sumx_reg[SUM_W-1:OUT_W-1]))
        begin
            jacx_next = sumx_reg[OUT_W-1:0];
        end
        else
        begin
            jacx_next = sumx_reg[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                          : {1'b0, {(OUT_W-1){1'b1}}};
        end
        if ((&sumy_reg[SUM_W-1:OUT_W-1]) || !(|sumy_reg[SUM_W-1:OUT_W-1]))
        begin
            jacy_next = sumy_reg[OUT_W-1:0];
        end
        else
        begin
            jacy_next = sumy_reg[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                          : {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld_reg[PIPE_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            jacx_reg <= jacx_next;
            jacy_reg <= jacy_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {jacy_reg, jacx_reg};

endmodule

@@ hw/rtl/mbj_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbj_checker
// Port-level checks of the mesh barycentric Jacobian unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module mbj_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Take input whenever the output side can drain
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked while output can drain");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output beat present after reset");

    // A missing output beat never blocks the input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("input beat stalled with empty output");

endmodule

bind mesh_barycentric_jacobian_unit mbj_checker u_mbj_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mesh_barycentric_jacobian_unit. Loads vertex and
// triangle tables over the input stream, sends pixel beats and compares each
// jac_x / jac_y beat with a local barycentric Jacobian predictor. Both stream
// sides idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    import mbj_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_VERTS    = 1024;
    localparam int NUM_TRIS     = 2048;
    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;
    localparam longint W_ONE    = 65536;
    localparam longint W_CLAMP  = longint'(1) << 47;

    typedef struct {
        logic [1:0]         kind;
        logic [10:0]        entry;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] var_x;
        logic signed [15:0] var_y;
        logic [9:0]         ca;
        logic [9:0]         cb;
        logic [9:0]         cc;
        logic [7:0]         px;
        logic [7:0]         py;
        logic [11:0]        label;
    } beat_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // entry_index, pos x/y, var x/y, corners a/b/c, pixel x/y, label
    logic [1:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // jac_x, jac_y

    // Local copy of the tables
    logic signed [15:0] vtx_px [NUM_VERTS];
    logic signed [15:0] vtx_py [NUM_VERTS];
    logic signed [15:0] vtx_vx [NUM_VERTS];
    logic signed [15:0] vtx_vy [NUM_VERTS];
    logic [29:0]        tri_corners [NUM_TRIS];
    int                 known_verts[$];
    int                 known_tris[$];
    bit                 vert_written [NUM_VERTS];
    bit                 tri_written [NUM_TRIS];

    logic [63:0] jac_expected[$];
    int          errors;
    int          idle_cycles;
    int          long_hold;
    bit          tx_burst;
    bit          rx_burst;
    int          rx_wait;

    mesh_barycentric_jacobian_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Predict jac_x / jac_y of one pixel from the local tables
    function automatic logic [63:0] jacobian_of(logic [7:0] px, logic [7:0] py,
                                                logic [11:0] label);
        longint vx[3], vy[3], qx[3], qy[3];
        longint tx, ty, e1x, e1y, e2x, e2y, dx, dy, d, a, b, w, sx, sy;
        logic [29:0] corners;
        int idx, j, k1, k2;
        sx = 0;
        sy = 0;
        if (label != 0 && label - 1 < NUM_TRIS)
        begin
            corners = tri_corners[label - 1];
            for (j = 0; j < 3; j++)
            begin
                idx = int'(corners[10*j +: 10]);
                vx[j] = longint'(vtx_px[idx]);
                vy[j] = longint'(vtx_py[idx]);
                qx[j] = longint'(vtx_vx[idx]);
                qy[j] = longint'(vtx_vy[idx]);
            end
            tx = longint'(px) * 64;
            ty = longint'(py) * 64;
            for (j = 0; j < 3; j++)
            begin
                k1 = (j + 1) % 3;
                k2 = (j + 2) % 3;
                e1x = vx[k1] - vx[j];
                e1y = vy[k1] - vy[j];
                e2x = vx[k2] - vx[j];
                e2y = vy[k2] - vy[j];
                dx = tx - vx[j];
                dy = ty - vy[j];
                d = e1x * e2y - e1y * e2x;
                if (d != 0)
                begin
                    a = dx * e2y - dy * e2x;
                    b = dy * e1x - dx * e1y;
                    w = ((d - a - b) * W_ONE) / d;
                    if (w > W_CLAMP)
                        w = W_CLAMP;
                    if (w < -W_CLAMP)
                        w = -W_CLAMP;
                    sx += (w * qx[j]) / 4096;
                    sy += (w * qy[j]) / 4096;
                end
            end
        end
        if (sx > 64'sd2147483647) sx = 64'sd2147483647;
        if (sx < -64'sd2147483648) sx = -64'sd2147483648;
        if (sy > 64'sd2147483647) sy = 64'sd2147483647;
        if (sy < -64'sd2147483648) sy = -64'sd2147483648;
        return {sy[31:0], sx[31:0]};
    endfunction

    // Update the tables or queue a result for one accepted beat
    function automatic void absorb_beat(beat_t b);
        case (b.kind)
            KIND_VERTEX:
                if (b.entry < NUM_VERTS)
                begin
                    vtx_px[b.entry] = b.pos_x;
                    vtx_py[b.entry] = b.pos_y;
                    vtx_vx[b.entry] = b.var_x;
                    vtx_vy[b.entry] = b.var_y;
                    if (!vert_written[b.entry])
                        known_verts.push_back(int'(b.entry));
                    vert_written[b.entry] = 1'b1;
                end
            KIND_TRIANGLE:
            begin
                tri_corners[b.entry] = {b.cc, b.cb, b.ca};
                if (!tri_written[b.entry])
                    known_tris.push_back(int'(b.entry));
                tri_written[b.entry] = 1'b1;
            end
            KIND_PIXEL:
                jac_expected.push_back(jacobian_of(b.px, b.py, b.label));
            default: ;
        endcase
    endfunction

    // Send one beat after a drawn gap; keep tvalid high across back-to-back beats
    task automatic send_beat(beat_t b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = b.kind;
        s_tdata  = {3'b0, b.label, b.py, b.px, b.cc, b.cb, b.ca,
                    b.var_y, b.var_x, b.pos_y, b.pos_x, b.entry};
        do @(posedge clk); while (!s_tready);
        absorb_beat(b);
        @(negedge clk);
    endtask

    // Beat with every field random; callers override what matters
    function automatic beat_t noise_beat(logic [1:0] kind);
        beat_t b;
        b.kind  = kind;
        b.entry = 11'($urandom);
        b.pos_x = 16'($urandom);
        b.pos_y = 16'($urandom);
        b.var_x = 16'($urandom);
        b.var_y = 16'($urandom);
        b.ca    = 10'($urandom);
        b.cb    = 10'($urandom);
        b.cc    = 10'($urandom);
        b.px    = 8'($urandom);
        b.py    = 8'($urandom);
        b.label = 12'($urandom);
        return b;
    endfunction

    task automatic send_vertex(int idx, int x, int y, int qx, int qy);
        beat_t b;
        b = noise_beat(KIND_VERTEX);
        b.entry = 11'(idx);
        b.pos_x = 16'(x);
        b.pos_y = 16'(y);
        b.var_x = 16'(qx);
        b.var_y = 16'(qy);
        send_beat(b);
    endtask

    task automatic send_triangle(int idx, int a, int bb, int c);
        beat_t b;
        b = noise_beat(KIND_TRIANGLE);
        b.entry = 11'(idx);
        b.ca = 10'(a);
        b.cb = 10'(bb);
        b.cc = 10'(c);
        send_beat(b);
    endtask

    task automatic send_pixel(int x, int y, int label);
        beat_t b;
        b = noise_beat(KIND_PIXEL);
        b.px = 8'(x);
        b.py = 8'(y);
        b.label = 12'(label);
        send_beat(b);
    endtask

    // Random beat of any kind; triangle corners and most pixel labels come from the tables
    task automatic send_random_beat();
        beat_t b;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            b = noise_beat(KIND_UNUSED);
        else if (r < 15 || known_verts.size() < 3)
        begin
            b = noise_beat(KIND_VERTEX);
            if ($urandom_range(0, 3) != 0)
                b.entry = 11'($urandom_range(0, 31));
            if ($urandom_range(0, 9) < 7)
            begin
                b.pos_x = 16'($urandom_range(0, 16383) - 64);
                b.pos_y = 16'($urandom_range(0, 16383) - 64);
            end
        end
        else if (r < 22 || known_tris.size() == 0)
        begin
            b = noise_beat(KIND_TRIANGLE);
            b.ca = 10'(known_verts[$urandom_range(0, known_verts.size() - 1)]);
            b.cb = 10'(known_verts[$urandom_range(0, known_verts.size() - 1)]);
            b.cc = 10'(known_verts[$urandom_range(0, known_verts.size() - 1)]);
            if ($urandom_range(0, 1) == 0)
                b.entry = 11'($urandom_range(0, 15));
        end
        else
        begin
            b = noise_beat(KIND_PIXEL);
            r = $urandom_range(0, 99);
            if (r < 6)
                b.label = 12'd0;
            else if (r < 12)
                b.label = 12'($urandom_range(NUM_TRIS + 1, 4095));
            else
                b.label = 12'(known_tris[$urandom_range(0, known_tris.size() - 1)] + 1);
        end
        send_beat(b);
    endtask

    // Extremes and named special cases
    task automatic test_directed();
        send_vertex(0, 0, 0, 32767, -32768);
        send_vertex(1, 64, 0, 4096, 4096);
        send_vertex(2, 0, 64, -4096, 100);
        send_triangle(0, 0, 1, 2);
        send_pixel(0, 0, 1);
        send_pixel(1, 1, 1);
        send_pixel(255, 255, 1);
        // tiny triangle far from the pixel: large weights of opposite sign
        send_vertex(3, 0, 0, -32768, 32767);
        send_vertex(4, 1, 0, -32768, 32767);
        send_vertex(5, 0, 1, -32768, 32767);
        send_triangle(1, 3, 4, 5);
        send_pixel(255, 255, 2);
        // collinear corners: zero determinant
        send_vertex(6, 128, 0, 1000, -1000);
        send_triangle(2, 0, 1, 6);
        send_pixel(10, 0, 3);
        // extreme positions and the last table entries
        send_vertex(1023, -32768, -32768, 32767, 32767);
        send_vertex(1022, 32767, -32768, -32768, -32768);
        send_triangle(2047, 1023, 1022, 0);
        send_pixel(128, 200, 2048);
        // write beyond vertex table, unused kind, no label, label past table
        send_vertex(2047, 5, 5, 5, 5);
        send_beat(noise_beat(KIND_UNUSED));
        send_pixel(7, 9, 0);
        send_pixel(255, 0, 4095);
        send_pixel(0, 255, 2049);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                tx_burst = !tx_burst;
            send_random_beat();
        end
        tx_burst = 1'b0;
    endtask

    // Stall the output long enough that the pipeline fills and input stalls
    task automatic test_backpressure();
        long_hold = LONG_HOLD;
        tx_burst = 1'b1;
        for (int i = 0; i < 150; i++)
        begin
            beat_t b;
            b = noise_beat(KIND_PIXEL);
            b.label = 12'(known_tris[$urandom_range(0, known_tris.size() - 1)] + 1);
            send_beat(b);
        end
        tx_burst = 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
    endtask

    // Output side: check each beat, then draw the next stall
    initial
    begin
        logic [63:0] want;
        m_tready = 1'b0;
        rx_wait = 0;
        rx_burst = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (jac_expected.size() == 0)
                begin
                    report_mismatch("unexpected beat jac_x", 32'h0, m_tdata[31:0]);
                end
                else
                begin
                    want = jac_expected.pop_front();
                    if (m_tdata[31:0] !== want[31:0])
                        report_mismatch("jac_x", want[31:0], m_tdata[31:0]);
                    if (m_tdata[63:32] !== want[63:32])
                        report_mismatch("jac_y", want[63:32], m_tdata[63:32]);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
            end
            @(negedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                m_tready = 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    // Watchdog on cycles with no beat moving on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        long_hold = 0;
        tx_burst = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = KIND_VERTEX;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(600);
        test_backpressure();
        test_random(550);
        s_tvalid = 1'b0;

        wait (jac_expected.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/mbj_pkg.sv
hw/rtl/mbj_ram.sv
hw/rtl/mbj_corner.sv
hw/rtl/mesh_barycentric_jacobian_unit.sv
hw/rtl/mbj_checker.sv
bench/testbench.sv
